// ----- rtl/core/cfsa_pkg.sv -----
`timescale 1ns / 1ps
// cfsa_pkg: shared types, constants and functions for the crc16 frame suffix appender
// no dependencies

package cfsa_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CAP_RESET   = 16'd256;
    localparam logic [7:0]  CLOSE_BRACE = 8'h7D;

    localparam int SFX_LEN   = 18;
    localparam int SFX_IDX_W = $clog2(SFX_LEN);
    localparam logic [SFX_IDX_W-1:0] SFX_LAST = SFX_IDX_W'(SFX_LEN - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cfsa_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       overflow;
    } cfsa_out_t;

    // tracker status seen by the output stage
    typedef struct packed {
        logic [15:0] crc;
        logic        ovf;
    } cfsa_trk_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h41 + {4'h0, n} - 8'd10;
        end
        return r;
    endfunction

    // ,"crc16":"XXXX"} CR LF
    function automatic logic [7:0] suffix_byte(input logic [SFX_IDX_W-1:0] idx,
                                               input logic [15:0] crc);
        logic [7:0] r;
        case (idx)
            5'd0:    r = 8'h2C;
            5'd1:    r = 8'h22;
            5'd2:    r = 8'h63;
            5'd3:    r = 8'h72;
            5'd4:    r = 8'h63;
            5'd5:    r = 8'h31;
            5'd6:    r = 8'h36;
            5'd7:    r = 8'h22;
            5'd8:    r = 8'h3A;
            5'd9:    r = 8'h22;
            5'd10:   r = hex_char(crc[15:12]);
            5'd11:   r = hex_char(crc[11:8]);
            5'd12:   r = hex_char(crc[7:4]);
            5'd13:   r = hex_char(crc[3:0]);
            5'd14:   r = 8'h22;
            5'd15:   r = 8'h7D;
            5'd16:   r = 8'h0D;
            5'd17:   r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/cfsa_crc_track.sv -----
`timescale 1ns / 1ps
// cfsa_crc_track: running crc, saturating frame length and capacity register
// depends on cfsa_pkg

module cfsa_crc_track (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                upd,
    input  logic [7:0]          data_byte,
    input  logic                clear,
    output cfsa_pkg::cfsa_trk_t trk
);
    import cfsa_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cap_reg;
    logic [15:0] len_inc;
    logic [16:0] total;

    assign len_inc = (len_reg == 16'hFFFF) ? len_reg : len_reg + 16'd1;
    assign total   = {1'b0, len_inc} + 17'(SFX_LEN);

    always_comb begin
        crc_next = crc_reg;
        len_next = len_reg;
        if (clear) begin
            crc_next = CRC_INIT;
            len_next = 16'd0;
        end else if (upd) begin
            crc_next = crc_byte(crc_reg, data_byte);
            len_next = len_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            len_reg <= 16'd0;
            cap_reg <= CAP_RESET;
        end else begin
            crc_reg <= crc_next;
            len_reg <= len_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // overflow status for the transaction being accepted now
    assign trk.crc = crc_reg;
    assign trk.ovf = (total >= {1'b0, cap_reg});

endmodule

// ----- rtl/core/cfsa_out_stage.sv -----
`timescale 1ns / 1ps
// cfsa_out_stage: output register and suffix sequencer
// depends on cfsa_pkg

module cfsa_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfsa_pkg::cfsa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cfsa_pkg::cfsa_out_t m_data,
    input  cfsa_pkg::cfsa_trk_t trk,
    output logic                sfx_done
);
    import cfsa_pkg::*;

    logic                 m_valid_reg, m_valid_next;
    cfsa_out_t            m_data_reg, m_data_next;
    logic                 sfx_active_reg, sfx_active_next;
    logic [SFX_IDX_W-1:0] sfx_idx_reg, sfx_idx_next;
    logic                 ovf_reg, ovf_next;
    logic                 out_free;
    logic                 in_accept;
    logic [15:0]          crc_final;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = out_free && !sfx_active_reg;
    assign in_accept = s_valid && s_ready;
    // crc including the implied closing brace
    assign crc_final = crc_byte(trk.crc, CLOSE_BRACE);

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        sfx_active_next = sfx_active_reg;
        sfx_idx_next    = sfx_idx_reg;
        ovf_next        = ovf_reg;
        sfx_done        = 1'b0;
        if (sfx_active_reg) begin
            if (out_free) begin
                m_valid_next          = 1'b1;
                m_data_next.out_byte  = suffix_byte(sfx_idx_reg, crc_final);
                m_data_next.frame_end = (sfx_idx_reg == SFX_LAST);
                m_data_next.overflow  = (sfx_idx_reg == SFX_LAST) && ovf_reg;
                if (sfx_idx_reg == SFX_LAST) begin
                    sfx_active_next = 1'b0;
                    sfx_done        = 1'b1;
                end else begin
                    sfx_idx_next = sfx_idx_reg + SFX_IDX_W'(1);
                end
            end
        end else if (in_accept) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = s_data.data_byte;
            m_data_next.frame_end = 1'b0;
            m_data_next.overflow  = 1'b0;
            if (s_data.last_byte) begin
                sfx_active_next = 1'b1;
                sfx_idx_next    = '0;
                ovf_next        = trk.ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            sfx_active_reg <= 1'b0;
            sfx_idx_reg    <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            sfx_active_reg <= sfx_active_next;
            sfx_idx_reg    <= sfx_idx_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ovf_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.overflow |-> m_data_reg.frame_end)
        else $error("overflow flagged outside frame end");

    a_last_starts_suffix: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_data.last_byte |=> sfx_active_reg && sfx_idx_reg == '0)
        else $error("suffix not started after last byte");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sfx_idx_reg <= SFX_LAST)
        else $error("suffix index out of range");

    a_end_closes_suffix: assert property (@(posedge aclk) disable iff (!aresetn)
        sfx_done |=> !sfx_active_reg && m_valid_reg && m_data_reg.frame_end)
        else $error("frame end not produced on suffix completion");

endmodule

// ----- rtl/core/crc16_frame_suffix_appender_core.sv -----
`timescale 1ns / 1ps
// Passes frame body bytes through one per cycle unless m_ready stalls the output, running
// CRC-16/CCITT-FALSE over them plus an implied closing brace; after the last byte it emits
// the 18-byte suffix ,"crc16":"XXXX"} CR LF with frame_end on the line feed, and overflow
// there when body length plus 18 is not below the capacity register. Each byte passes
// through a single output register; after a last byte it holds the suffix, and s_ready
// stays low until the line feed is loaded, so no byte is accepted during the suffix. The
// output is registered: m_valid is set in the cycle after a byte is accepted. Capacity
// resets to 256; the user must write it through cfg_we/cfg_wdata while idle (not enforced).
// depends on cfsa_pkg, cfsa_crc_track, cfsa_out_stage

module crc16_frame_suffix_appender_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfsa_pkg::cfsa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cfsa_pkg::cfsa_out_t m_data
);
    import cfsa_pkg::*;

    cfsa_trk_t trk;
    logic      sfx_done;
    logic      in_accept;

    assign in_accept = s_valid && s_ready;

    cfsa_crc_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .upd       (in_accept),
        .data_byte (s_data.data_byte),
        .clear     (sfx_done),
        .trk       (trk)
    );

    cfsa_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .trk      (trk),
        .sfx_done (sfx_done)
    );

endmodule
